// ===== design/nrcw_pkg.sv =====
// Shared types, constants and helpers for the NewReno congestion window block.
// No dependencies; used by the interfaces, the divider and the top level.
package nrcw_pkg;

    localparam int unsigned MSS_W    = 14;
    localparam int unsigned OP_W     = 2;
    localparam int unsigned TIME_W   = 64;
    localparam int unsigned ACKED_W  = 16;
    localparam int unsigned WIN_W    = 32;
    localparam int unsigned PROD_W   = MSS_W + ACKED_W;
    localparam int unsigned DIV_CNT_W = $clog2(PROD_W);

    // count value of the final quotient bit in the serial divider
    localparam logic [DIV_CNT_W-1:0] DIV_LAST_STEP = DIV_CNT_W'(PROD_W - 1);

    localparam logic [OP_W-1:0] OP_ACK   = 2'd0;
    localparam logic [OP_W-1:0] OP_LOSS  = 2'd1;
    localparam logic [OP_W-1:0] OP_RESET = 2'd2;

    localparam int unsigned MSS_RESET_I = 1252;
    localparam int unsigned INIT_CAP_I  = 14720;
    localparam int unsigned TWO_MSS_I   = 2 * MSS_RESET_I;
    localparam int unsigned TEN_MSS_I   = 10 * MSS_RESET_I;
    localparam int unsigned INIT_LO_I   = (TWO_MSS_I < INIT_CAP_I) ? INIT_CAP_I : TWO_MSS_I;
    localparam int unsigned INIT_WIN_I  = (TEN_MSS_I < INIT_LO_I) ? TEN_MSS_I : INIT_LO_I;

    localparam logic [MSS_W-1:0] MSS_RESET   = MSS_W'(MSS_RESET_I);
    localparam logic [WIN_W-1:0] INIT_WINDOW = WIN_W'(INIT_WIN_I);
    localparam logic [WIN_W-1:0] WIN_ALL_ONES = '1;

    typedef struct packed {
        logic start;
    } t_div_ctrl;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_status;

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_DSTART = 4'b0010,
        S_DWAIT  = 4'b0100,
        S_DONE   = 4'b1000
    } t_state;

    function automatic logic [WIN_W-1:0] sat_add(input logic [WIN_W-1:0] a,
                                                 input logic [WIN_W-1:0] b);
        logic [WIN_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[WIN_W] ? WIN_ALL_ONES : s[WIN_W-1:0];
    endfunction

endpackage

// ===== design/nrcw_ifs.sv =====
// Valid/ready channel interfaces for events, results and the datagram size register.
// Depends on nrcw_pkg for field widths.
interface nrcw_event_if;
    logic                            valid;
    logic                            ready;
    logic [nrcw_pkg::OP_W-1:0]       operation;
    logic [nrcw_pkg::TIME_W-1:0]     send_stamp;
    logic [nrcw_pkg::ACKED_W-1:0]    ack_len;
    logic [nrcw_pkg::TIME_W-1:0]     now;
    logic                            cwnd_limited;
    modport source (output valid, operation, send_stamp, ack_len, now, cwnd_limited,
                    input ready);
    modport sink   (input valid, operation, send_stamp, ack_len, now, cwnd_limited,
                    output ready);
endinterface

interface nrcw_result_if;
    logic                        valid;
    logic                        ready;
    logic [nrcw_pkg::WIN_W-1:0]  window_bytes;
    logic [nrcw_pkg::WIN_W-1:0]  slow_start_threshold;
    logic                        in_slow_start;
    logic                        in_recovery;
    modport source (output valid, window_bytes, slow_start_threshold, in_slow_start,
                    in_recovery, input ready);
    modport sink   (input valid, window_bytes, slow_start_threshold, in_slow_start,
                    in_recovery, output ready);
endinterface

interface nrcw_cfg_if;
    logic                        valid;
    logic                        ready;
    logic [nrcw_pkg::MSS_W-1:0]  max_datagram_size;
    modport source (output valid, max_datagram_size, input ready);
    modport sink   (input valid, max_datagram_size, output ready);
endinterface

// ===== design/nrcw_divider.sv =====
// Restoring serial divider, one quotient bit per cycle.
// Depends on nrcw_pkg for widths and the control/status structs.
module nrcw_divider (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  nrcw_pkg::t_div_ctrl          i_ctrl,
    input  logic [nrcw_pkg::PROD_W-1:0]  i_dividend,
    input  logic [nrcw_pkg::WIN_W-1:0]   i_divisor,
    output nrcw_pkg::t_div_status        o_status,
    output logic [nrcw_pkg::PROD_W-1:0]  o_quotient
);

    logic                              r_busy, n_busy;
    logic                              r_done, n_done;
    logic [nrcw_pkg::DIV_CNT_W-1:0]    r_cnt, n_cnt;
    logic [nrcw_pkg::WIN_W-1:0]        r_rem, n_rem;
    logic [nrcw_pkg::WIN_W-1:0]        r_div, n_div;
    logic [nrcw_pkg::PROD_W-1:0]       r_quo, n_quo;
    logic [nrcw_pkg::WIN_W:0]          trial;
    logic [nrcw_pkg::WIN_W:0]          diff;

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_div  = r_div;
        n_quo  = r_quo;
        // shift in the next dividend bit, subtract if it fits
        trial  = {r_rem, r_quo[nrcw_pkg::PROD_W-1]};
        diff   = trial - {1'b0, r_div};
        if (i_ctrl.start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_rem  = '0;
            n_div  = i_divisor;
            n_quo  = i_dividend;
        end else if (r_busy) begin
            if (trial >= {1'b0, r_div}) begin
                n_rem = diff[nrcw_pkg::WIN_W-1:0];
                n_quo = {r_quo[nrcw_pkg::PROD_W-2:0], 1'b1};
            end else begin
                n_rem = trial[nrcw_pkg::WIN_W-1:0];
                n_quo = {r_quo[nrcw_pkg::PROD_W-2:0], 1'b0};
            end
            n_cnt = r_cnt + nrcw_pkg::DIV_CNT_W'(1);
            if (r_cnt == nrcw_pkg::DIV_LAST_STEP) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_rem <= n_rem;
        r_div <= n_div;
        r_quo <= n_quo;
    end

    assign o_status.busy = r_busy;
    assign o_status.done = r_done;
    assign o_quotient    = r_quo;

endmodule

// ===== design/newreno_congestion_window.sv =====
// Newreno congestion window tracker: one result word per event word. Loss, reset,
// ignored acks and slow start acks pass through S_DONE to the output register; an
// ack in congestion avoidance first passes S_DSTART and S_DWAIT, where the serial
// divider forms max_datagram_size * acked_bytes / window one quotient bit per cycle
// (30 steps). No new event is taken until the current result has been handed to
// the output register; that register lets the result wait while the next event
// is taken. The datagram size register is always ready and must be written only
// while the block is idle. Depends on nrcw_pkg, nrcw_ifs and nrcw_divider.
module newreno_congestion_window (
    input  logic          i_clk,
    input  logic          i_rst_n,
    nrcw_cfg_if.sink      i_cfg,
    nrcw_event_if.sink    i_event,
    nrcw_result_if.source o_result
);

    nrcw_pkg::t_state                r_state, n_state;
    logic [nrcw_pkg::MSS_W-1:0]      r_mss;
    logic [nrcw_pkg::WIN_W-1:0]      r_window, n_window;
    logic [nrcw_pkg::WIN_W-1:0]      r_thresh, n_thresh;
    logic [nrcw_pkg::TIME_W-1:0]     r_rec, n_rec;
    logic [nrcw_pkg::PROD_W-1:0]     r_prod;

    logic                            r_out_valid, n_out_valid;
    logic [nrcw_pkg::WIN_W-1:0]      r_out_win, n_out_win;
    logic [nrcw_pkg::WIN_W-1:0]      r_out_thr, n_out_thr;
    logic                            r_out_ss, n_out_ss;
    logic                            r_out_rec, n_out_rec;

    logic                            accept;
    logic                            after_rec;
    logic [nrcw_pkg::WIN_W-1:0]      min_win;
    logic [nrcw_pkg::WIN_W-1:0]      half_win;
    logic [nrcw_pkg::WIN_W-1:0]      divisor;
    nrcw_pkg::t_div_ctrl             div_ctrl;
    nrcw_pkg::t_div_status           div_st;
    logic [nrcw_pkg::PROD_W-1:0]     quotient;

    assign i_cfg.ready   = 1'b1;
    assign i_event.ready = (r_state == nrcw_pkg::S_IDLE);
    assign accept        = i_event.valid && i_event.ready;

    assign after_rec = i_event.send_stamp > r_rec;
    assign min_win   = {{(nrcw_pkg::WIN_W - nrcw_pkg::MSS_W - 1){1'b0}}, r_mss, 1'b0};
    assign half_win  = {1'b0, r_window[nrcw_pkg::WIN_W-1:1]};
    assign divisor   = (r_window == '0) ? nrcw_pkg::WIN_W'(1) : r_window;

    assign div_ctrl.start = (r_state == nrcw_pkg::S_DSTART);

    nrcw_divider u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctrl     (div_ctrl),
        .i_dividend (r_prod),
        .i_divisor  (divisor),
        .o_status   (div_st),
        .o_quotient (quotient)
    );

    always_comb begin
        n_state     = r_state;
        n_window    = r_window;
        n_thresh    = r_thresh;
        n_rec       = r_rec;
        n_out_valid = r_out_valid && !o_result.ready;
        n_out_win   = r_out_win;
        n_out_thr   = r_out_thr;
        n_out_ss    = r_out_ss;
        n_out_rec   = r_out_rec;
        case (r_state)
            nrcw_pkg::S_IDLE: begin
                if (accept) begin
                    n_state = nrcw_pkg::S_DONE;
                    case (i_event.operation)
                        nrcw_pkg::OP_ACK: begin
                            if (after_rec) begin
                                n_rec = '0;
                                if (i_event.cwnd_limited) begin
                                    if (r_window < r_thresh) begin
                                        n_window = nrcw_pkg::sat_add(r_window,
                                            nrcw_pkg::WIN_W'(i_event.ack_len));
                                    end else begin
                                        n_state = nrcw_pkg::S_DSTART;
                                    end
                                end
                            end
                        end
                        nrcw_pkg::OP_LOSS: begin
                            if (after_rec) begin
                                n_rec    = i_event.now;
                                n_window = (half_win < min_win) ? min_win : half_win;
                                n_thresh = (half_win < min_win) ? min_win : half_win;
                            end
                        end
                        nrcw_pkg::OP_RESET: begin
                            n_window = min_win;
                            n_rec    = '0;
                        end
                        default: ;
                    endcase
                end
            end
            nrcw_pkg::S_DSTART: n_state = nrcw_pkg::S_DWAIT;
            nrcw_pkg::S_DWAIT: begin
                if (div_st.done) begin
                    n_window = nrcw_pkg::sat_add(r_window, nrcw_pkg::WIN_W'(quotient));
                    n_state  = nrcw_pkg::S_DONE;
                end
            end
            nrcw_pkg::S_DONE: begin
                // publish once the output register is free or being drained
                if (!r_out_valid || o_result.ready) begin
                    n_out_valid = 1'b1;
                    n_out_win   = r_window;
                    n_out_thr   = r_thresh;
                    n_out_ss    = r_window < r_thresh;
                    n_out_rec   = r_rec != '0;
                    n_state     = nrcw_pkg::S_IDLE;
                end
            end
            default: n_state = nrcw_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= nrcw_pkg::S_IDLE;
            r_mss       <= nrcw_pkg::MSS_RESET;
            r_window    <= nrcw_pkg::INIT_WINDOW;
            r_thresh    <= nrcw_pkg::WIN_ALL_ONES;
            r_rec       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_window    <= n_window;
            r_thresh    <= n_thresh;
            r_rec       <= n_rec;
            r_out_valid <= n_out_valid;
            if (i_cfg.valid && i_cfg.ready) begin
                r_mss <= i_cfg.max_datagram_size;
            end
        end
        if (accept) begin
            r_prod <= nrcw_pkg::PROD_W'(r_mss) * nrcw_pkg::PROD_W'(i_event.ack_len);
        end
        r_out_win <= n_out_win;
        r_out_thr <= n_out_thr;
        r_out_ss  <= n_out_ss;
        r_out_rec <= n_out_rec;
    end

    assign o_result.valid                = r_out_valid;
    assign o_result.window_bytes         = r_out_win;
    assign o_result.slow_start_threshold = r_out_thr;
    assign o_result.in_slow_start        = r_out_ss;
    assign o_result.in_recovery          = r_out_rec;

    a_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_st.done |-> r_state == nrcw_pkg::S_DWAIT)
        else $error("divider finished outside of the wait state");

    a_busy_when_waiting: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == nrcw_pkg::S_DWAIT && !div_st.done) |-> div_st.busy)
        else $error("waiting on an idle divider");

    a_accept_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> !i_event.ready)
        else $error("event taken while the previous one is in flight");

    a_publish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == nrcw_pkg::S_DONE && (!r_out_valid || o_result.ready))
            |=> (o_result.valid && r_state == nrcw_pkg::S_IDLE))
        else $error("finished word not moved to the output register");

endmodule

// ===== bench/newreno_congestion_window_test.sv =====
// Self-checking bench for newreno_congestion_window: directed and random event words,
// a local window predictor, and random stalls on both channels.
// Depends on nrcw_pkg, the channel interfaces in nrcw_ifs and the block itself.
module newreno_congestion_window_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [nrcw_pkg::OP_W-1:0] OP_UNUSED = 2'd3;
    localparam int unsigned STALL_LIMIT  = 4000;
    localparam int unsigned MAX_REPORTED = 100;
    localparam int unsigned LONG_HOLD    = 300;
    localparam logic [nrcw_pkg::TIME_W-1:0] TIME_ONES = '1;

    typedef struct packed {
        logic [nrcw_pkg::WIN_W-1:0] window_bytes;
        logic [nrcw_pkg::WIN_W-1:0] slow_start_threshold;
        logic                       in_slow_start;
        logic                       in_recovery;
    } t_window_report;

    logic i_clk;
    logic i_rst_n;

    nrcw_cfg_if    cfg ();
    nrcw_event_if  ev ();
    nrcw_result_if res ();

    newreno_congestion_window dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (cfg),
        .i_event  (ev),
        .o_result (res)
    );

    // predictor state
    logic [nrcw_pkg::MSS_W-1:0]  mss_m;
    logic [nrcw_pkg::WIN_W-1:0]  cwnd_m;
    logic [nrcw_pkg::WIN_W-1:0]  ssthresh_m;
    logic [nrcw_pkg::TIME_W-1:0] recovery_m;

    t_window_report pending_reports[$];

    int fails = 0;
    int stall_cycles = 0;
    bit tx_idle_on = 1'b1;
    bit rx_idle_on = 1'b1;
    int rx_hold = 0;
    int rx_gap = 0;
    logic [nrcw_pkg::TIME_W-1:0] clock_us = 64'd5000;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic [nrcw_pkg::WIN_W-1:0] window_floor();
        return nrcw_pkg::WIN_W'({mss_m, 1'b0});
    endfunction

    function automatic logic [nrcw_pkg::WIN_W-1:0] saturating_grow(
        input logic [nrcw_pkg::WIN_W-1:0] w,
        input logic [63:0]                inc
    );
        logic [63:0] sum;
        sum = 64'(w) + inc;
        return (sum > 64'hffff_ffff) ? '1 : sum[nrcw_pkg::WIN_W-1:0];
    endfunction

    function automatic t_window_report predict_window_update(
        input logic [nrcw_pkg::OP_W-1:0]    op,
        input logic [nrcw_pkg::TIME_W-1:0]  sent,
        input logic [nrcw_pkg::ACKED_W-1:0] acked,
        input logic [nrcw_pkg::TIME_W-1:0]  t_now,
        input logic                         limited
    );
        logic [63:0]                divisor;
        logic [63:0]                inc;
        logic [nrcw_pkg::WIN_W-1:0] halved;
        t_window_report             r;
        case (op)
            nrcw_pkg::OP_ACK: begin
                if (sent > recovery_m) begin
                    recovery_m = '0;
                    if (limited) begin
                        if (cwnd_m < ssthresh_m) begin
                            cwnd_m = saturating_grow(cwnd_m, 64'(acked));
                        end else begin
                            // zero window only with a zero datagram size
                            divisor = (cwnd_m == '0) ? 64'd1 : 64'(cwnd_m);
                            inc = (64'(mss_m) * 64'(acked)) / divisor;
                            cwnd_m = saturating_grow(cwnd_m, inc);
                        end
                    end
                end
            end
            nrcw_pkg::OP_LOSS: begin
                if (sent > recovery_m) begin
                    recovery_m = t_now;
                    halved = cwnd_m >> 1;
                    if (halved < window_floor())
                        halved = window_floor();
                    cwnd_m = halved;
                    ssthresh_m = halved;
                end
            end
            nrcw_pkg::OP_RESET: begin
                cwnd_m = window_floor();
                recovery_m = '0;
            end
            default: ;
        endcase
        r.window_bytes = cwnd_m;
        r.slow_start_threshold = ssthresh_m;
        r.in_slow_start = (cwnd_m < ssthresh_m);
        r.in_recovery = (recovery_m != '0);
        return r;
    endfunction

    function automatic void report_mismatch(input string field, input logic [63:0] want,
                                            input logic [63:0] got);
        fails++;
        if (fails <= MAX_REPORTED)
            $error("%s: expected %0d, got %0d", field, want, got);
    endfunction

    // result checker and stall watchdog
    always @(posedge i_clk) begin : check_results
        t_window_report want;
        if (i_rst_n === 1'b1) begin
            if ((ev.valid && ev.ready) || (res.valid && res.ready) || (cfg.valid && cfg.ready))
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("Some tests failed");
                $finish;
            end
            if (res.valid === 1'b1 && res.ready === 1'b1) begin
                if (pending_reports.size() == 0) begin
                    fails++;
                    if (fails <= MAX_REPORTED)
                        $error("result word with no event outstanding");
                end else begin
                    want = pending_reports.pop_front();
                    if (res.window_bytes !== want.window_bytes)
                        report_mismatch("window_bytes", 64'(want.window_bytes),
                                        64'(res.window_bytes));
                    if (res.slow_start_threshold !== want.slow_start_threshold)
                        report_mismatch("slow_start_threshold",
                                        64'(want.slow_start_threshold),
                                        64'(res.slow_start_threshold));
                    if (res.in_slow_start !== want.in_slow_start)
                        report_mismatch("in_slow_start", 64'(want.in_slow_start),
                                        64'(res.in_slow_start));
                    if (res.in_recovery !== want.in_recovery)
                        report_mismatch("in_recovery", 64'(want.in_recovery),
                                        64'(res.in_recovery));
                end
            end
        end
    end

    // result side: random gaps, plus a long hold when requested
    initial begin : result_receiver
        res.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (rx_hold > 0) begin
                res.ready <= 1'b0;
                rx_hold--;
            end else if (rx_gap > 0) begin
                res.ready <= 1'b0;
                rx_gap--;
            end else if (rx_idle_on && $urandom_range(0, 7) == 0) begin
                res.ready <= 1'b0;
                rx_gap = $urandom_range(0, 7);
            end else begin
                res.ready <= 1'b1;
            end
        end
    end

    task automatic send_event(input logic [nrcw_pkg::OP_W-1:0] op,
                              input logic [nrcw_pkg::TIME_W-1:0] sent,
                              input logic [nrcw_pkg::ACKED_W-1:0] acked,
                              input logic [nrcw_pkg::TIME_W-1:0] t_now,
                              input logic limited);
        @(negedge i_clk);
        if (tx_idle_on && $urandom_range(0, 5) == 0) begin
            ev.valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge i_clk);
        end
        ev.valid <= 1'b1;
        ev.operation <= op;
        ev.send_stamp <= sent;
        ev.ack_len <= acked;
        ev.now <= t_now;
        ev.cwnd_limited <= limited;
        do @(posedge i_clk); while (ev.ready !== 1'b1);
        pending_reports.push_back(predict_window_update(op, sent, acked, t_now, limited));
    endtask

    task automatic wait_for_reports();
        @(negedge i_clk);
        ev.valid <= 1'b0;
        while (pending_reports.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_datagram_size(input logic [nrcw_pkg::MSS_W-1:0] size);
        wait_for_reports();
        @(negedge i_clk);
        cfg.valid <= 1'b1;
        cfg.max_datagram_size <= size;
        do @(posedge i_clk); while (cfg.ready !== 1'b1);
        mss_m = size;
        @(negedge i_clk);
        cfg.valid <= 1'b0;
    endtask

    // mostly plausible ack/loss flows on a rising clock, some noise words
    task automatic send_traffic(input int count);
        int pick;
        logic [nrcw_pkg::TIME_W-1:0] sent;
        logic [nrcw_pkg::ACKED_W-1:0] acked;
        for (int i = 0; i < count; i++) begin
            if (recovery_m > clock_us)
                clock_us = recovery_m;
            if (clock_us[63:60] == 4'hf) begin
                clock_us = 64'd5000;
                send_event(nrcw_pkg::OP_RESET, '0, '0, '0, 1'b0);
            end else begin
                clock_us += 64'($urandom_range(1, 300));
                sent = clock_us - 64'($urandom_range(0, 600));
                pick = $urandom_range(0, 9);
                if (pick < 7)
                    acked = nrcw_pkg::ACKED_W'(mss_m);
                else if (pick < 9)
                    acked = nrcw_pkg::ACKED_W'($urandom);
                else
                    acked = nrcw_pkg::ACKED_W'($urandom_range(0, 100));
                pick = $urandom_range(0, 99);
                if (pick < 62)
                    send_event(nrcw_pkg::OP_ACK, sent, acked, clock_us,
                               $urandom_range(0, 9) != 0);
                else if (pick < 80)
                    send_event(nrcw_pkg::OP_LOSS, sent, acked, clock_us,
                               1'($urandom_range(0, 1)));
                else if (pick < 85)
                    send_event(nrcw_pkg::OP_RESET, {$urandom, $urandom}, acked,
                               {$urandom, $urandom}, 1'($urandom_range(0, 1)));
                else if (pick < 88)
                    send_event(OP_UNUSED, {$urandom, $urandom}, acked, {$urandom, $urandom},
                               1'($urandom_range(0, 1)));
                else
                    send_event(nrcw_pkg::OP_W'($urandom_range(0, 3)), {$urandom, $urandom},
                               nrcw_pkg::ACKED_W'($urandom), {$urandom, $urandom},
                               1'($urandom_range(0, 1)));
            end
        end
    endtask

    task automatic test_reset_state();
        send_event(OP_UNUSED, '0, '0, '0, 1'b0);
        send_event(nrcw_pkg::OP_ACK, '0, '1, '0, 1'b1);   // sent at recovery start: ignored
        send_event(nrcw_pkg::OP_ACK, 64'd1, '0, '0, 1'b1);
    endtask

    // threshold is all ones only before the first loss, so grow in slow start now
    task automatic test_slow_start_growth();
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        repeat (40)
            send_event(nrcw_pkg::OP_ACK, 64'd1, '1, '0, 1'b1);
        send_event(nrcw_pkg::OP_ACK, 64'd2, '1, '0, 1'b1);
        send_event(nrcw_pkg::OP_ACK, 64'd3, '1, '0, 1'b0);
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
    endtask

    task automatic test_directed();
        send_event(nrcw_pkg::OP_LOSS, 64'd1, '0, '0, 1'b0);          // loss at time zero
        send_event(nrcw_pkg::OP_LOSS, 64'd1, '0, 64'd100, 1'b0);
        send_event(nrcw_pkg::OP_LOSS, 64'd100, '0, 64'd200, 1'b0);   // inside recovery
        send_event(nrcw_pkg::OP_ACK, 64'd50, '1, '0, 1'b1);          // inside recovery
        send_event(nrcw_pkg::OP_ACK, 64'd101, '1, '0, 1'b0);    // leaves recovery, no growth
        send_event(nrcw_pkg::OP_ACK, 64'd102, '1, '0, 1'b1);
        send_event(nrcw_pkg::OP_RESET, 64'd103, '0, '0, 1'b0);
        send_event(nrcw_pkg::OP_ACK, 64'd300, '1, '0, 1'b1);
        send_event(nrcw_pkg::OP_LOSS, TIME_ONES, '0, TIME_ONES, 1'b0);
        send_event(nrcw_pkg::OP_ACK, TIME_ONES, '1, TIME_ONES, 1'b1);
        send_event(nrcw_pkg::OP_LOSS, TIME_ONES, '1, '0, 1'b1);
        send_event(OP_UNUSED, TIME_ONES, '1, TIME_ONES, 1'b1);
        send_event(nrcw_pkg::OP_RESET, TIME_ONES, '1, TIME_ONES, 1'b1);
        send_event(nrcw_pkg::OP_LOSS, 64'd5, '0, 64'd1, 1'b0);       // floors at two datagrams
        send_event(nrcw_pkg::OP_ACK, 64'd6, '1, '0, 1'b1);
        send_event(nrcw_pkg::OP_ACK, 64'd7, '0, '0, 1'b1);
        send_event(nrcw_pkg::OP_ACK, 64'd8, 16'd1, '0, 1'b1);
    endtask

    task automatic test_datagram_size_extremes();
        write_datagram_size('0);
        send_event(nrcw_pkg::OP_RESET, '0, '0, '0, 1'b0);
        send_event(nrcw_pkg::OP_LOSS, 64'd1, '0, '0, 1'b0);  // window and threshold to zero
        send_event(nrcw_pkg::OP_ACK, 64'd1, '1, '0, 1'b1);   // zero divisor taken as one
        send_event(nrcw_pkg::OP_ACK, 64'd2, 16'h5555, '0, 1'b1);
        write_datagram_size('1);
        send_event(nrcw_pkg::OP_RESET, '0, '0, '0, 1'b0);
        send_event(nrcw_pkg::OP_ACK, 64'd3, '1, '0, 1'b1);
        send_event(nrcw_pkg::OP_LOSS, 64'd5, '0, 64'd7, 1'b0);
        send_event(nrcw_pkg::OP_ACK, 64'd8, '1, '0, 1'b1);
        write_datagram_size(nrcw_pkg::MSS_RESET);
        send_event(nrcw_pkg::OP_RESET, '0, '0, '0, 1'b0);
    endtask

    task automatic test_backpressure();
        tx_idle_on = 1'b0;
        rx_hold = LONG_HOLD;
        send_traffic(12);
        tx_idle_on = 1'b1;
    endtask

    task automatic test_sender_pause();
        send_traffic(10);
        wait_for_reports();
        send_traffic(10);
    endtask

    task automatic test_random();
        logic [nrcw_pkg::MSS_W-1:0] sizes[5];
        sizes[0] = nrcw_pkg::MSS_W'(1200);
        sizes[1] = nrcw_pkg::MSS_W'(9000);
        sizes[2] = nrcw_pkg::MSS_W'($urandom_range(1200, 9000));
        sizes[3] = '1;
        sizes[4] = nrcw_pkg::MSS_RESET;
        foreach (sizes[k]) begin
            write_datagram_size(sizes[k]);
            if (k == 4) begin
                send_traffic(20);
                tx_idle_on = 1'b0;
                rx_idle_on = 1'b0;
                send_traffic(80);
            end else begin
                send_traffic(100);
            end
        end
    endtask

    initial begin : run_tests
        int unsigned ten_mss;
        int unsigned low_mss;
        i_rst_n = 1'b0;
        ev.valid = 1'b0;
        ev.operation = nrcw_pkg::OP_ACK;
        ev.send_stamp = '0;
        ev.ack_len = '0;
        ev.now = '0;
        ev.cwnd_limited = 1'b0;
        cfg.valid = 1'b0;
        cfg.max_datagram_size = '0;

        mss_m = nrcw_pkg::MSS_RESET;
        ten_mss = 10 * int'(mss_m);
        low_mss = 2 * int'(mss_m);
        if (low_mss < nrcw_pkg::INIT_CAP_I)
            low_mss = nrcw_pkg::INIT_CAP_I;
        cwnd_m = nrcw_pkg::WIN_W'((ten_mss < low_mss) ? ten_mss : low_mss);
        ssthresh_m = '1;
        recovery_m = '0;

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_state();
        test_slow_start_growth();
        test_directed();
        test_datagram_size_extremes();
        test_backpressure();
        test_sender_pause();
        test_random();

        wait_for_reports();
        repeat (50) @(posedge i_clk);
        if (fails == 0 && pending_reports.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
